@@ hw/rtl/lbtw_pkg.sv @@
// Shared types, constants and a helper function for the log2 bucket timer wheel.
`default_nettype none
package lbtw_pkg;

	localparam int TICK_W  = 32;
	localparam int TAG_W   = 8;
	localparam int INTV_W  = 24;
	localparam int BLEN_W  = 6;

	localparam logic CMD_ADD    = 1'b0;
	localparam logic CMD_UPDATE = 1'b1;

	localparam logic KIND_EXPIRED  = 1'b0;
	localparam logic KIND_REJECTED = 1'b1;

	typedef struct packed {
		logic              cmd;
		logic [TAG_W-1:0]  timer_tag;
		logic [INTV_W-1:0] interval;
		logic [TICK_W-1:0] time_now;
	} req_t;

	typedef struct packed {
		logic             kind;
		logic [TAG_W-1:0] expired_tag;
		logic             last;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DEC,
		S_REJ,
		S_WALK,
		S_EXP
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_in;
		logic do_add;
		logic do_rej;
		logic upd_start;
		logic walk_step;
		logic emit;
	} ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_upd;
		logic full;
		logic walk_done;
		logic due_any;
		logic out_free;
	} stat_t;

	// Number of significant bits in v (zero for zero).
	function automatic logic [BLEN_W-1:0] bit_len(input logic [TICK_W-1:0] v);
		logic [BLEN_W-1:0] n;
		n = '0;
		for (int i = 0; i < TICK_W; i++) begin
			if (v[i]) begin
				n = BLEN_W'(i + 1);
			end
		end
		return n;
	endfunction

endpackage
`default_nettype wire

@@ hw/rtl/lbtw_if.sv @@
// Valid/ready channel interfaces for request and result items.
`default_nettype none
interface lbtw_req_if;
	logic              valid;
	logic              ready;
	lbtw_pkg::req_t    data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface lbtw_rsp_if;
	logic              valid;
	logic              ready;
	lbtw_pkg::rsp_t    data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/lbtw_ctrl.sv @@
// Sequencing state machine of the timer wheel.
`default_nettype none
module lbtw_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_ready,
	input  wire lbtw_pkg::stat_t stat,
	output lbtw_pkg::ctl_t       ctl
);

	lbtw_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lbtw_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			lbtw_pkg::S_IDLE: begin
				if (req_valid) state_d = lbtw_pkg::S_DEC;
			end
			lbtw_pkg::S_DEC: begin
				if (stat.is_upd) state_d = lbtw_pkg::S_WALK;
				else if (stat.full) state_d = lbtw_pkg::S_REJ;
				else state_d = lbtw_pkg::S_IDLE;
			end
			lbtw_pkg::S_REJ: begin
				if (stat.out_free) state_d = lbtw_pkg::S_IDLE;
			end
			lbtw_pkg::S_WALK: begin
				if (stat.walk_done) state_d = lbtw_pkg::S_EXP;
			end
			lbtw_pkg::S_EXP: begin
				if (!stat.due_any) state_d = lbtw_pkg::S_IDLE;
			end
			default: state_d = lbtw_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		ctl       = '0;
		req_ready = 1'b0;
		case (state_q)
			lbtw_pkg::S_IDLE: begin
				req_ready   = 1'b1;
				ctl.load_in = req_valid;
			end
			lbtw_pkg::S_DEC: begin
				ctl.do_add    = !stat.is_upd && !stat.full;
				ctl.upd_start = stat.is_upd;
			end
			lbtw_pkg::S_REJ: begin
				ctl.do_rej = stat.out_free;
			end
			lbtw_pkg::S_WALK: begin
				ctl.walk_step = !stat.walk_done;
			end
			lbtw_pkg::S_EXP: begin
				ctl.emit = stat.due_any && stat.out_free;
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ hw/rtl/lbtw_dp.sv @@
// Slot table, tick state, per-slot compare lanes and result register.
`default_nettype none
module lbtw_dp #(
	parameter int SLOTS  = 16,
	parameter int LEVELS = 32
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire lbtw_pkg::req_t req_data,
	input  wire logic           rsp_ready,
	output logic                rsp_valid,
	output lbtw_pkg::rsp_t      rsp_data,
	input  wire lbtw_pkg::ctl_t ctl,
	output lbtw_pkg::stat_t     stat
);

	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int LW = $clog2(LEVELS);
	localparam int TW = lbtw_pkg::TICK_W;

	logic                      valid_q [SLOTS];
	logic [lbtw_pkg::TAG_W-1:0] tag_q  [SLOTS];
	logic [TW-1:0]             end_q   [SLOTS];
	logic [LW-1:0]             lvl_q   [SLOTS];
	// older_q[i][j] set: slot i holds an older stamp than slot j.
	logic [SLOTS-1:0]          older_q [SLOTS];

	logic [TW-1:0]  tick_q, last_time_q;
	logic [LW-1:0]  walk_lvl_q;
	lbtw_pkg::req_t in_q;
	logic           out_valid_q;
	lbtw_pkg::rsp_t out_q;

	logic [TW-1:0]              elapsed, adj, new_tick, gate;
	logic [lbtw_pkg::BLEN_W-1:0] bl_adj, bl_x;
	logic [LW-1:0]              add_lvl, top_lvl;
	logic [SW-1:0]              free_idx, pick_idx;
	logic                       full;
	logic [SLOTS-1:0]           mv, mv_walk, due, pick;
	logic [TW-1:0]              rem [SLOTS];
	logic                       out_free;

	assign elapsed  = in_q.time_now - last_time_q;
	assign adj      = {{(TW - lbtw_pkg::INTV_W){1'b0}}, in_q.interval} + elapsed;
	assign bl_adj   = lbtw_pkg::bit_len(adj - TW'(1));
	assign new_tick = tick_q + elapsed;
	assign bl_x     = lbtw_pkg::bit_len(tick_q ^ new_tick);
	assign gate     = TW'(1) << (walk_lvl_q - LW'(1));

	always_comb begin
		if (adj == '0 || adj[TW-1]) begin
			add_lvl = '0;
		end else if (bl_adj > lbtw_pkg::BLEN_W'(LEVELS - 1)) begin
			add_lvl = LW'(LEVELS - 1);
		end else begin
			add_lvl = bl_adj[LW-1:0];
		end
		if (bl_x > lbtw_pkg::BLEN_W'(LEVELS - 1)) begin
			top_lvl = LW'(LEVELS - 1);
		end else begin
			top_lvl = bl_x[LW-1:0];
		end
	end

	// Lowest free slot.
	always_comb begin
		free_idx = '0;
		full     = 1'b1;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx = SW'(i);
				full     = 1'b0;
			end
		end
	end

	// One compare lane per slot.
	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			rem[i]     = end_q[i] - tick_q;
			mv_walk[i] = valid_q[i] && (lvl_q[i] == walk_lvl_q)
				&& (rem[i][TW-1] || rem[i] <= gate);
			due[i]     = valid_q[i] && (lvl_q[i] == '0)
				&& (rem[i][TW-1] || rem[i] == '0);
		end
	end

	// Oldest due entry: no other due entry is older.
	always_comb begin
		pick_idx = '0;
		for (int i = 0; i < SLOTS; i++) begin
			pick[i] = due[i];
			for (int j = 0; j < SLOTS; j++) begin
				if (j != i && due[j] && older_q[j][i]) pick[i] = 1'b0;
			end
			if (pick[i]) pick_idx = SW'(i);
		end
	end

	always_comb begin
		mv = '0;
		if (ctl.walk_step) begin
			mv = mv_walk;
		end else if (ctl.do_add) begin
			mv[free_idx] = 1'b1;
		end
	end

	assign out_free = !out_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) valid_q[i] <= 1'b0;
			tick_q      <= '0;
			last_time_q <= '0;
			walk_lvl_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.do_add) valid_q[free_idx] <= 1'b1;
			if (ctl.emit) valid_q[pick_idx] <= 1'b0;
			if (ctl.upd_start) begin
				tick_q      <= new_tick;
				last_time_q <= in_q.time_now;
				walk_lvl_q  <= top_lvl;
			end else if (ctl.walk_step) begin
				walk_lvl_q <= walk_lvl_q - LW'(1);
			end
			if (ctl.do_rej || ctl.emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_in) in_q <= req_data;
		if (ctl.do_add) begin
			tag_q[free_idx] <= in_q.timer_tag;
			end_q[free_idx] <= tick_q + adj;
			lvl_q[free_idx] <= add_lvl;
		end
		for (int i = 0; i < SLOTS; i++) begin
			if (ctl.walk_step && mv[i]) lvl_q[i] <= walk_lvl_q - LW'(1);
			// A fresh stamp makes the entry younger than everything outside its batch.
			for (int j = 0; j < SLOTS; j++) begin
				if (mv[i] && !mv[j]) begin
					older_q[i][j] <= 1'b0;
				end else if (mv[j] && !mv[i]) begin
					older_q[i][j] <= 1'b1;
				end
			end
		end
		if (ctl.do_rej) begin
			out_q.kind        <= lbtw_pkg::KIND_REJECTED;
			out_q.expired_tag <= in_q.timer_tag;
			out_q.last        <= 1'b1;
		end else if (ctl.emit) begin
			out_q.kind        <= lbtw_pkg::KIND_EXPIRED;
			out_q.expired_tag <= tag_q[pick_idx];
			out_q.last        <= ((due & ~pick) == '0);
		end
	end

	assign rsp_valid      = out_valid_q;
	assign rsp_data       = out_q;
	assign stat.is_upd    = (in_q.cmd == lbtw_pkg::CMD_UPDATE);
	assign stat.full      = full;
	assign stat.walk_done = (walk_lvl_q == '0);
	assign stat.due_any   = |due;
	assign stat.out_free  = out_free;

	a_pick_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(pick)) else $error("more than one oldest due entry");

	a_emit_frees: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |=> !valid_q[$past(pick_idx)]) else $error("emitted slot still valid");

	a_walk_down: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.walk_step |=> walk_lvl_q == $past(walk_lvl_q) - LW'(1))
		else $error("walk level did not step down");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.emit || ctl.do_rej) |-> out_free) else $error("result register overrun");

endmodule
`default_nettype wire

@@ hw/rtl/log2_bucket_timer_wheel_core.sv @@
// Top level of the log2 bucket timer wheel: controller plus datapath.
//
//  channel | dir | payload                                 | meaning
//  --------+-----+-----------------------------------------+-------------------------------
//  req     | in  | cmd, timer_tag, interval, time_now      | add a timer or advance time
//  rsp     | out | kind, expired_tag, last                 | expired or rejected timer
//
// An add item passes the decode step and returns to idle, where the next item can be taken;
// a rejected add also passes the reject step, which waits until the result register is free.
// An update item passes the decode step, then walks down from the starting walk level
// (the bit length of the tick change, capped at LEVELS-1; one level per cycle
// over the whole slot table in parallel) to level zero, then emits the expiring timers,
// one per cycle through the single result register when rsp takes each result.
// A result stalled on rsp holds the controller in the expiry or reject step; the
// request side is accepted only in the idle state, while a finished result may still wait.
// Reset (arst_n low) empties the slot table and zeroes the tick and the last update time.
`default_nettype none
module log2_bucket_timer_wheel_core #(
	parameter int SLOTS  = 16,
	parameter int LEVELS = 32
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	lbtw_req_if.sink    req,
	lbtw_rsp_if.source  rsp
);

	lbtw_pkg::ctl_t  ctl;
	lbtw_pkg::stat_t stat;
	logic            ready;

	// The controller decides the step; the datapath holds all slot and tick state.
	lbtw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	lbtw_dp #(
		.SLOTS  (SLOTS),
		.LEVELS (LEVELS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req.data),
		.rsp_ready (rsp.ready),
		.rsp_valid (rsp.valid),
		.rsp_data  (rsp.data),
		.ctl       (ctl),
		.stat      (stat)
	);

	assign req.ready = ready;

	// An item is only taken while idle, and only idle takes items.
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |-> ctl.load_in) else $error("accepted item not loaded");

	a_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.do_add, ctl.do_rej, ctl.upd_start, ctl.walk_step, ctl.emit}))
		else $error("conflicting datapath commands");

	a_busy_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load_in |=> !req.ready) else $error("ready while an item is in work");

endmodule
`default_nettype wire
